>>> sv/sha1de_pkg.sv
// sha1de_pkg: shared types, constants and round functions of the sha-1 digest engine
// used by sha1de_ctrl, sha1de_datapath and sha1_digest_engine_top; no dependencies
package sha1de_pkg;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_DATA   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd60;
  localparam logic [5:0] PAD_LIMIT  = 6'd56;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] WORD_LAST  = 3'd4;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  // initial chaining value, index 0 is H0
  localparam logic [4:0][31:0] IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  typedef enum logic [1:0] {
    SEL_DATA = 2'd0,
    SEL_MARK = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic       init;
    logic       push;
    logic       count_len;
    logic       set_ovf;
    logic       load;
    logic       round;
    logic       add;
    byte_sel_t  sel;
    logic [6:0] round_idx;
    logic [2:0] out_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       ovf;
    logic       len_wrap;
  } dp_stat_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) begin
      k = 32'h5A827999;
    end else if (r < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (r < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
    end else if (r < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

>>> sv/sha1de_datapath.sv
// sha1de_datapath: block shift line, message schedule, round unit, chaining words
// and length/overflow tracking; depends on sha1de_pkg
module sha1de_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sha1de_pkg::dp_cmd_t  cmd,
  input  logic [7:0]           data_byte,
  output sha1de_pkg::dp_stat_t stat,
  output logic [31:0]          digest_word,
  output logic                 too_long
);

  logic [15:0][31:0] w;
  logic [4:0][31:0]  chain;
  logic [31:0]       a, b, c, d, e;
  logic [31:0]       bit_length;
  logic [5:0]        fill;
  logic              ovf;
  logic [7:0]        push_byte;
  logic [31:0]       w_new;
  logic [31:0]       t;

  always_comb begin
    case (cmd.sel)
      sha1de_pkg::SEL_DATA: push_byte = data_byte;
      sha1de_pkg::SEL_MARK: push_byte = sha1de_pkg::PAD_MARK;
      sha1de_pkg::SEL_ZERO: push_byte = 8'd0;
      sha1de_pkg::SEL_LEN: begin
        case (fill[1:0])
          2'd0:    push_byte = bit_length[31:24];
          2'd1:    push_byte = bit_length[23:16];
          2'd2:    push_byte = bit_length[15:8];
          default: push_byte = bit_length[7:0];
        endcase
      end
      default: push_byte = 8'd0;
    endcase
  end

  // schedule word sixteen rounds ahead
  assign w_new = {w[13][30:0] ^ w[8][30:0] ^ w[2][30:0] ^ w[0][30:0],
                  w[13][31] ^ w[8][31] ^ w[2][31] ^ w[0][31]};

  assign t = {a[26:0], a[31:27]} + sha1de_pkg::round_f(cmd.round_idx, b, c, d) + e
           + sha1de_pkg::round_k(cmd.round_idx) + w[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain      <= sha1de_pkg::IV;
      fill       <= 6'd0;
      bit_length <= 32'd0;
      ovf        <= 1'b0;
    end else begin
      if (cmd.init) begin
        chain      <= sha1de_pkg::IV;
        fill       <= 6'd0;
        bit_length <= 32'd0;
        ovf        <= 1'b0;
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.push) begin
        fill <= fill + 6'd1;
        if (cmd.count_len) begin
          bit_length <= bit_length + 32'd8;
        end
      end
      if (cmd.add) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      for (int j = 0; j < 15; j++) begin
        w[j] <= {w[j][23:0], w[j+1][31:24]};
      end
      w[15] <= {w[15][23:0], push_byte};
    end else if (cmd.round) begin
      for (int j = 0; j < 15; j++) begin
        w[j] <= w[j+1];
      end
      w[15] <= w_new;
    end
    if (cmd.load) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (cmd.round) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  assign stat.fill     = fill;
  assign stat.ovf      = ovf;
  assign stat.len_wrap = &bit_length[31:3];

  assign digest_word = chain[cmd.out_idx];
  assign too_long    = ovf;

endmodule

>>> sv/sha1de_ctrl.sv
// sha1de_ctrl: sequencer for byte intake, padding, round stepping and digest output
// depends on sha1de_pkg; drives sha1de_datapath through dp_cmd_t
module sha1de_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           action,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           word_index,
  output logic                 last_word,
  input  sha1de_pkg::dp_stat_t stat,
  output sha1de_pkg::dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MARK  = 8'b0000_0010,
    ST_ZERO  = 8'b0000_0100,
    ST_LEN   = 8'b0000_1000,
    ST_LOAD  = 8'b0001_0000,
    ST_ROUND = 8'b0010_0000,
    ST_ADD   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  state_t     state, state_next;
  logic [6:0] round_ctr, round_ctr_next;
  logic [2:0] out_idx, out_idx_next;
  logic       finishing, finishing_next;
  logic       last_blk, last_blk_next;
  logic       pending, pending_next;
  logic       block_full;

  assign block_full = (stat.fill == sha1de_pkg::BLOCK_LAST);

  always_comb begin
    state_next     = state;
    round_ctr_next = round_ctr;
    out_idx_next   = out_idx;
    finishing_next = finishing;
    last_blk_next  = last_blk;
    pending_next   = pending;
    cmd            = '0;
    cmd.sel        = sha1de_pkg::SEL_DATA;
    cmd.round_idx  = round_ctr;
    cmd.out_idx    = out_idx;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            sha1de_pkg::ACT_START: cmd.init = 1'b1;
            sha1de_pkg::ACT_DATA: begin
              if (!stat.ovf) begin
                if (stat.len_wrap) begin
                  cmd.set_ovf = 1'b1;
                end else begin
                  cmd.push      = 1'b1;
                  cmd.count_len = 1'b1;
                  if (block_full) begin
                    state_next = ST_LOAD;
                  end
                end
              end
            end
            sha1de_pkg::ACT_FINISH: begin
              finishing_next = 1'b1;
              state_next     = ST_MARK;
            end
            default: ;
          endcase
        end
      end
      ST_MARK: begin
        cmd.push     = 1'b1;
        cmd.sel      = sha1de_pkg::SEL_MARK;
        pending_next = (stat.fill >= sha1de_pkg::PAD_LIMIT);
        state_next   = block_full ? ST_LOAD : ST_ZERO;
      end
      ST_ZERO: begin
        if (stat.fill == sha1de_pkg::LEN_POS && !pending) begin
          state_next = ST_LEN;
        end else begin
          cmd.push = 1'b1;
          cmd.sel  = sha1de_pkg::SEL_ZERO;
          if (block_full) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_LEN: begin
        cmd.push = 1'b1;
        cmd.sel  = sha1de_pkg::SEL_LEN;
        if (block_full) begin
          last_blk_next = 1'b1;
          state_next    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load       = 1'b1;
        round_ctr_next = 7'd0;
        state_next     = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round      = 1'b1;
        round_ctr_next = round_ctr + 7'd1;
        if (round_ctr == sha1de_pkg::ROUND_LAST) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add      = 1'b1;
        pending_next = 1'b0;
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (last_blk) begin
          out_idx_next = 3'd0;
          state_next   = ST_OUT;
        end else begin
          state_next = ST_ZERO;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          if (out_idx == sha1de_pkg::WORD_LAST) begin
            cmd.init       = 1'b1;
            finishing_next = 1'b0;
            last_blk_next  = 1'b0;
            out_idx_next   = 3'd0;
            state_next     = ST_IDLE;
          end else begin
            out_idx_next = out_idx + 3'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round_ctr <= 7'd0;
      out_idx   <= 3'd0;
      finishing <= 1'b0;
      last_blk  <= 1'b0;
      pending   <= 1'b0;
    end else begin
      state     <= state_next;
      round_ctr <= round_ctr_next;
      out_idx   <= out_idx_next;
      finishing <= finishing_next;
      last_blk  <= last_blk_next;
      pending   <= pending_next;
    end
  end

  assign in_ready   = (state == ST_IDLE);
  assign out_valid  = (state == ST_OUT);
  assign word_index = out_idx;
  assign last_word  = (out_idx == sha1de_pkg::WORD_LAST);

endmodule

>>> sv/sha1_digest_engine_top.sv
// sha1_digest_engine_top: sha-1 over a byte stream, five digest word beats per finish
// each byte is taken while idle; every 64th byte starts a compression (load, 80 rounds, add)
// finish: a mark byte, zero bytes, four length bytes, one or two compressions
// no byte is taken during a compression; the single round unit does one round per cycle
// synchronous reset loads the initial digest and clears length, fill and overflow
// depends on sha1de_pkg, sha1de_ctrl, sha1de_datapath
module sha1_digest_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        too_long
);

  sha1de_pkg::dp_cmd_t  cmd;
  sha1de_pkg::dp_stat_t stat;

  sha1de_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .word_index (word_index),
    .last_word  (last_word),
    .stat       (stat),
    .cmd        (cmd)
  );

  sha1de_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .stat        (stat),
    .digest_word (digest_word),
    .too_long    (too_long)
  );

endmodule

>>> verif/tb.sv
// tb: self-checking testbench for sha1_digest_engine_top, byte stream in, five digest beats out
// a scoreboard class predicts each digest from the accepted input beats; depends on sha1de_pkg
module tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 140;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
    logic        long_flag;
  } digest_beat_t;

  class digest_scoreboard;
    bit [7:0]     blk_bytes[64];
    bit [31:0]    chain[5];
    int unsigned  fill;
    bit [31:0]    bit_count;
    bit           ovf;
    digest_beat_t digest_due[$];
    int           errors;

    function new();
      foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = 32'h67452301;
      chain[1] = 32'hEFCDAB89;
      chain[2] = 32'h98BADCFE;
      chain[3] = 32'h10325476;
      chain[4] = 32'hC3D2E1F0;
      fill = 0;
      bit_count = 32'd0;
      ovf = 1'b0;
    endfunction

    function bit [31:0] rol(bit [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      bit [31:0] w[16];
      bit [31:0] a, b, c, d, e, f, k, t;
      int i;
      for (i = 0; i < 16; i++) begin
        w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (i = 0; i < 80; i++) begin
        if (i >= 16) begin
          w[i % 16] = rol(w[(i - 3) % 16] ^ w[(i - 8) % 16] ^ w[(i - 14) % 16] ^ w[i % 16], 1);
        end
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = 32'h5A827999;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = 32'h6ED9EBA1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d;
          k = 32'hCA62C1D6;
        end
        t = rol(a, 5) + f + e + k + w[i % 16];
        e = d;
        d = c;
        c = rol(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void absorb_byte(bit [7:0] value);
      if (ovf) return;
      // length would wrap past 2^32 bits
      if (bit_count > 32'hFFFFFFF7) begin
        ovf = 1'b1;
        return;
      end
      blk_bytes[fill] = value;
      bit_count += 32'd8;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void pad_and_emit();
      int unsigned pos;
      digest_beat_t beat;
      int i;
      pos = fill;
      blk_bytes[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          blk_bytes[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 60) begin
        blk_bytes[pos] = 8'h00;
        pos++;
      end
      blk_bytes[60] = bit_count[31:24];
      blk_bytes[61] = bit_count[23:16];
      blk_bytes[62] = bit_count[15:8];
      blk_bytes[63] = bit_count[7:0];
      compress();
      for (i = 0; i < 5; i++) begin
        beat.word = chain[i];
        beat.idx = 3'(i);
        beat.last = (i == 4);
        beat.long_flag = ovf;
        digest_due.push_back(beat);
      end
      restart();
    endfunction

    function void note_beat_in(logic [1:0] act, logic [7:0] value);
      case (act)
        sha1de_pkg::ACT_START: restart();
        sha1de_pkg::ACT_DATA: absorb_byte(value);
        sha1de_pkg::ACT_FINISH: pad_and_emit();
        default: ;
      endcase
    endfunction

    function void check_digest_beat(logic [31:0] word, logic [2:0] idx, logic last,
                                    logic long_flag);
      digest_beat_t exp_beat;
      if (digest_due.size() == 0) begin
        $error("unexpected digest beat: digest_word %h word_index %0d", word, idx);
        errors++;
        return;
      end
      exp_beat = digest_due.pop_front();
      if (word !== exp_beat.word) begin
        $error("digest_word: expected %h, got %h", exp_beat.word, word);
        errors++;
      end
      if (idx !== exp_beat.idx) begin
        $error("word_index: expected %0d, got %0d", exp_beat.idx, idx);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $error("last_word: expected %b, got %b", exp_beat.last, last);
        errors++;
      end
      if (long_flag !== exp_beat.long_flag) begin
        $error("too_long: expected %b, got %b", exp_beat.long_flag, long_flag);
        errors++;
      end
    endfunction

    function int pending();
      return digest_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = sha1de_pkg::ACT_START;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        too_long;

  logic steady = 1'b0;
  int   sent = 0;
  int   pad_lens[12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  digest_scoreboard sb = new();

  sha1_digest_engine_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digest_word(digest_word),
    .word_index (word_index),
    .last_word  (last_word),
    .too_long   (too_long)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_beat_in(action, data_byte);
      if (out_valid && out_ready) begin
        sb.check_digest_beat(digest_word, word_index, last_word, too_long);
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 19);
  end

  task automatic send_beat(input logic [1:0] act, input logic [7:0] value);
    while (!steady && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    data_byte <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_message(input int len, input bit with_start);
    int j;
    if (with_start) send_beat(sha1de_pkg::ACT_START, 8'($urandom_range(255)));
    for (j = 0; j < len; j++) begin
      if ($urandom_range(29) == 0) send_beat(ACT_UNUSED, 8'($urandom_range(255)));
      send_beat(sha1de_pkg::ACT_DATA, 8'($urandom_range(255)));
    end
    send_beat(sha1de_pkg::ACT_FINISH, 8'($urandom_range(255)));
  endtask

  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stall = 0;
      else stall++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int r;
    int len;
    int base;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty message right after reset, no start
    send_beat(sha1de_pkg::ACT_FINISH, 8'h00);
    // extreme bytes, ignored byte on start and finish, unused code
    send_beat(sha1de_pkg::ACT_START, 8'hFF);
    send_beat(sha1de_pkg::ACT_DATA, 8'h00);
    send_beat(sha1de_pkg::ACT_DATA, 8'hFF);
    send_beat(sha1de_pkg::ACT_DATA, 8'h61);
    send_beat(ACT_UNUSED, 8'h5A);
    send_beat(sha1de_pkg::ACT_FINISH, 8'hC3);
    // "abc"
    send_beat(sha1de_pkg::ACT_START, 8'h00);
    send_beat(sha1de_pkg::ACT_DATA, 8'h61);
    send_beat(sha1de_pkg::ACT_DATA, 8'h62);
    send_beat(sha1de_pkg::ACT_DATA, 8'h63);
    send_beat(sha1de_pkg::ACT_FINISH, 8'h00);
    // restart in the middle of a message
    send_beat(sha1de_pkg::ACT_START, 8'h00);
    send_beat(sha1de_pkg::ACT_DATA, 8'h11);
    send_beat(sha1de_pkg::ACT_START, 8'hA5);
    send_beat(sha1de_pkg::ACT_DATA, 8'h22);
    send_beat(sha1de_pkg::ACT_FINISH, 8'h00);

    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      steady <= (sent - base >= 60) && (sent - base < 110);
      r = $urandom_range(99);
      if (r < 10) begin
        send_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
      end else begin
        r = $urandom_range(99);
        if (r < 55) len = $urandom_range(12);
        else if (r < 85) len = pad_lens[$urandom_range(11)];
        else len = $urandom_range(140, 65);
        if (len > RANDOM_ITEMS - (sent - base)) len = RANDOM_ITEMS - (sent - base);
        send_message(len, $urandom_range(9) != 0);
      end
    end
    in_valid <= 1'b0;
    steady <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sha1de_pkg.sv
sv/sha1de_datapath.sv
sv/sha1de_ctrl.sv
sv/sha1_digest_engine_top.sv
verif/tb.sv
